### sv/hierarchical_timer_wheel_defines.svh
// ----------------------------------------------------------------------------
// Timer wheel assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef HIERARCHICAL_TIMER_WHEEL_DEFINES_SVH
`define HIERARCHICAL_TIMER_WHEEL_DEFINES_SVH

// cond must hold at every edge out of reset
`define HTW_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define HTW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define HTW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/htw_pkg.sv
// ----------------------------------------------------------------------------
// Timer wheel package
// Sizes, operation codes, sequencer steps and slot filing functions.
// ----------------------------------------------------------------------------
`default_nettype none

package htw_pkg;

	localparam int TIMER_COUNT = 64;
	localparam int ROOT_BITS   = 8;
	localparam int LEVEL_BITS  = 6;
	localparam int LEVELS      = 4;

	localparam int OP_W    = 2;
	localparam int ID_W    = 6;
	localparam int TICK_W  = 32;
	localparam int LINK_W  = 7;
	localparam int K_W     = 2;

	localparam int ROOT_SIZE  = 1 << ROOT_BITS;
	localparam int LEVEL_SIZE = 1 << LEVEL_BITS;
	localparam int SLOT_COUNT = ROOT_SIZE + LEVELS * LEVEL_SIZE;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int NODE_DEPTH = 1 << ID_W;
	localparam int GUARD_W    = $clog2(TIMER_COUNT + 1);

	localparam logic [LINK_W-1:0] NIL     = 7'h7F;
	localparam logic [LINK_W-1:0] TC_LINK = LINK_W'(TIMER_COUNT);

	localparam logic [OP_W-1:0] OP_ARM    = 2'd0;
	localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_DEC,
		ST_U0, ST_U1, ST_ARM, ST_CANCEL,
		ST_F0, ST_F1, ST_F2,
		ST_C0, ST_C1, ST_W0, ST_W1, ST_WN, ST_LVL,
		ST_E0, ST_E1, ST_X0, ST_X1, ST_X2,
		ST_RSP
	} step_t;

	typedef enum logic [1:0] {
		FR_ARM, FR_CAS, FR_EXP
	} fret_t;

	typedef struct packed {
		step_t step;
		logic  take;
	} cmd_t;

	typedef struct packed {
		logic            clr_done;
		logic            id_ok;
		logic            id_active;
		logic            root_zero;
		logic            head_ok;
		logic            more;
		logic            lvl_stop;
		logic            out_free;
		logic            per_nz;
		logic [OP_W-1:0] op;
	} sts_t;

	// index of an expiry within upper level lvl (1 is the lowest upper level)
	function automatic logic [LEVEL_BITS-1:0] lvl_idx(input int lvl,
		input logic [TICK_W-1:0] e);
		logic [63:0] e64;
		e64 = {32'b0, e};
		return LEVEL_BITS'(e64 >> (ROOT_BITS + (lvl - 1) * LEVEL_BITS));
	endfunction

	function automatic logic [SLOT_W-1:0] upper_slot(input int lvl,
		input logic [TICK_W-1:0] e);
		return SLOT_W'(ROOT_SIZE + (lvl - 1) * LEVEL_SIZE) + SLOT_W'(lvl_idx(lvl, e));
	endfunction

	// pick the slot for an expiry by its distance from the current tick
	function automatic logic [SLOT_W-1:0] file_slot(input logic [TICK_W-1:0] e,
		input logic [TICK_W-1:0] tick);
		logic [TICK_W-1:0] d;
		logic [63:0]       d64;
		logic [SLOT_W-1:0] s;
		d   = e - tick;
		d64 = {32'b0, d};
		if ((d64 >> ROOT_BITS) == 64'd0) begin
			s = SLOT_W'(e[ROOT_BITS-1:0]);
		end else if ((d64 >> (ROOT_BITS + LEVEL_BITS)) == 64'd0) begin
			s = upper_slot(1, e);
		end else if ((d64 >> (ROOT_BITS + 2 * LEVEL_BITS)) == 64'd0) begin
			s = upper_slot(2, e);
		end else if ((d64 >> (ROOT_BITS + 3 * LEVEL_BITS)) == 64'd0) begin
			s = upper_slot(3, e);
		end else if (d[TICK_W-1]) begin
			// already overdue: fire on the current root slot
			s = SLOT_W'(tick[ROOT_BITS-1:0]);
		end else begin
			s = upper_slot(4, e);
		end
		return s;
	endfunction

endpackage

`default_nettype wire

### sv/htw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module htw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/htw_ctrl.sv
// ----------------------------------------------------------------------------
// Timer wheel controller
// Sequencer that steps the datapath through arm, cancel, cascade and expiry.
// ----------------------------------------------------------------------------
`default_nettype none

module htw_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire htw_pkg::sts_t sts,
	output htw_pkg::cmd_t     cmd
);

	htw_pkg::step_t state_q, state_d;
	htw_pkg::fret_t fret_q, fret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htw_pkg::ST_CLR;
			fret_q  <= htw_pkg::FR_ARM;
		end else begin
			state_q <= state_d;
			fret_q  <= fret_d;
		end
	end

	always_comb begin
		state_d = state_q;
		fret_d  = fret_q;
		unique case (state_q)
			htw_pkg::ST_CLR: begin
				if (sts.clr_done) state_d = htw_pkg::ST_IDLE;
			end
			htw_pkg::ST_IDLE: begin
				if (in_valid) state_d = htw_pkg::ST_DEC;
			end
			htw_pkg::ST_DEC: begin
				priority if (sts.op == htw_pkg::OP_ARM) begin
					if (!sts.id_ok) state_d = htw_pkg::ST_RSP;
					else if (sts.id_active) state_d = htw_pkg::ST_U0;
					else state_d = htw_pkg::ST_ARM;
				end else if (sts.op == htw_pkg::OP_CANCEL) begin
					state_d = (sts.id_ok && sts.id_active) ? htw_pkg::ST_U0 : htw_pkg::ST_RSP;
				end else if (sts.op == htw_pkg::OP_TICK) begin
					state_d = sts.root_zero ? htw_pkg::ST_C0 : htw_pkg::ST_E0;
				end else begin
					state_d = htw_pkg::ST_RSP;
				end
			end
			htw_pkg::ST_U0: state_d = htw_pkg::ST_U1;
			htw_pkg::ST_U1: begin
				state_d = (sts.op == htw_pkg::OP_ARM) ? htw_pkg::ST_ARM : htw_pkg::ST_CANCEL;
			end
			htw_pkg::ST_ARM: begin
				state_d = htw_pkg::ST_F0;
				fret_d  = htw_pkg::FR_ARM;
			end
			htw_pkg::ST_CANCEL: state_d = htw_pkg::ST_RSP;
			htw_pkg::ST_F0: state_d = htw_pkg::ST_F1;
			htw_pkg::ST_F1: state_d = htw_pkg::ST_F2;
			htw_pkg::ST_F2: begin
				priority if (fret_q == htw_pkg::FR_ARM) state_d = htw_pkg::ST_RSP;
				else if (fret_q == htw_pkg::FR_CAS) state_d = htw_pkg::ST_WN;
				else state_d = htw_pkg::ST_X2;
			end
			htw_pkg::ST_C0: state_d = htw_pkg::ST_C1;
			htw_pkg::ST_C1: state_d = sts.head_ok ? htw_pkg::ST_W0 : htw_pkg::ST_LVL;
			htw_pkg::ST_W0: state_d = htw_pkg::ST_W1;
			htw_pkg::ST_W1: begin
				state_d = htw_pkg::ST_F0;
				fret_d  = htw_pkg::FR_CAS;
			end
			htw_pkg::ST_WN: state_d = sts.more ? htw_pkg::ST_W0 : htw_pkg::ST_LVL;
			htw_pkg::ST_LVL: state_d = sts.lvl_stop ? htw_pkg::ST_E0 : htw_pkg::ST_C0;
			htw_pkg::ST_E0: state_d = htw_pkg::ST_E1;
			htw_pkg::ST_E1: state_d = sts.head_ok ? htw_pkg::ST_X0 : htw_pkg::ST_RSP;
			htw_pkg::ST_X0: state_d = htw_pkg::ST_X1;
			htw_pkg::ST_X1: begin
				// hold until the output register frees up
				if (sts.out_free) begin
					if (sts.per_nz) begin
						state_d = htw_pkg::ST_F0;
						fret_d  = htw_pkg::FR_EXP;
					end else begin
						state_d = htw_pkg::ST_X2;
					end
				end
			end
			htw_pkg::ST_X2: state_d = sts.more ? htw_pkg::ST_X0 : htw_pkg::ST_IDLE;
			htw_pkg::ST_RSP: begin
				if (sts.out_free) state_d = htw_pkg::ST_IDLE;
			end
			default: state_d = htw_pkg::ST_CLR;
		endcase
	end

	always_comb begin
		in_stall = (state_q != htw_pkg::ST_IDLE);
		cmd.step = state_q;
		cmd.take = in_valid && (state_q == htw_pkg::ST_IDLE);
	end

endmodule

`default_nettype wire

### sv/htw_dp.sv
// ----------------------------------------------------------------------------
// Timer wheel datapath
// Slot and node memories, tick counter, walk registers and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hierarchical_timer_wheel_defines.svh"

module htw_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire htw_pkg::cmd_t               cmd,
	output htw_pkg::sts_t                    sts,
	input  wire logic [htw_pkg::OP_W-1:0]    operation,
	input  wire logic [htw_pkg::ID_W-1:0]    timer_id,
	input  wire logic [htw_pkg::TICK_W-1:0]  due_time,
	input  wire logic [htw_pkg::TICK_W-1:0]  period,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             expired_valid,
	output logic      [htw_pkg::ID_W-1:0]    expired_id,
	output logic                             status,
	output logic                             last
);

	localparam int SW = htw_pkg::SLOT_W;
	localparam int IW = htw_pkg::ID_W;
	localparam int LW = htw_pkg::LINK_W;
	localparam int TW = htw_pkg::TICK_W;
	localparam int GW = htw_pkg::GUARD_W;

	// control state
	logic [TW-1:0]              tick_q;
	logic [htw_pkg::NODE_DEPTH-1:0] active_q;
	logic [SW-1:0]              clr_q;
	logic [GW-1:0]              guard_q;
	logic                       out_valid_q;

	// transaction and walk registers
	logic [htw_pkg::OP_W-1:0]   op_q;
	logic [IW-1:0]              id_q;
	logic [TW-1:0]              due_q;
	logic [TW-1:0]              per_q;
	logic                       stat_q;
	logic [htw_pkg::K_W-1:0]    k_q;
	logic                       izero_q;
	logic [LW-1:0]              cur_q;
	logic [LW-1:0]              succ_q;
	logic [TW-1:0]              exp_q;
	logic [IW-1:0]              fid_q;
	logic [SW-1:0]              slot_q;
	logic [LW-1:0]              tail_q;
	logic                       out_ev_q;
	logic [IW-1:0]              out_id_q;
	logic                       out_st_q;
	logic                       out_last_q;

	// memory ports
	logic          hd_re, hd_we, tl_re, tl_we;
	logic [SW-1:0] hd_raddr, hd_waddr, tl_raddr, tl_waddr;
	logic [LW-1:0] hd_wdata, hd_rdata, tl_wdata, tl_rdata;
	logic          nx_re, nx_we, pv_re, pv_we;
	logic [IW-1:0] nx_raddr, nx_waddr, pv_raddr, pv_waddr;
	logic [LW-1:0] nx_wdata, nx_rdata, pv_wdata, pv_rdata;
	logic          ex_re, ex_we, pd_re, pd_we, ns_re, ns_we;
	logic [IW-1:0] ex_raddr, ex_waddr, pd_raddr, pd_waddr, ns_raddr, ns_waddr;
	logic [TW-1:0] ex_wdata, ex_rdata, pd_wdata, pd_rdata;
	logic [SW-1:0] ns_wdata, ns_rdata;

	logic [SW-1:0]                 rslot, fslot, cslot;
	logic [htw_pkg::LEVEL_BITS-1:0] cidx;
	logic [TW-1:0]                 arm_exp, rearm_exp;
	logic [IW-1:0]                 cur_id;
	logic                          out_free, out_load, guard_lt, more, x_last, per_nz;

	assign cur_id    = cur_q[IW-1:0];
	assign rslot     = SW'(tick_q[htw_pkg::ROOT_BITS-1:0]);
	assign fslot     = htw_pkg::file_slot(exp_q, tick_q);
	assign arm_exp   = tick_q + due_q;
	assign rearm_exp = tick_q + pd_rdata;
	assign per_nz    = (pd_rdata != '0);

	always_comb begin
		unique case (k_q)
			2'd0: cidx = htw_pkg::lvl_idx(1, tick_q);
			2'd1: cidx = htw_pkg::lvl_idx(2, tick_q);
			2'd2: cidx = htw_pkg::lvl_idx(3, tick_q);
			2'd3: cidx = htw_pkg::lvl_idx(4, tick_q);
			default: cidx = '0;
		endcase
	end
	assign cslot = SW'(htw_pkg::ROOT_SIZE) + SW'({k_q, cidx});

	assign guard_lt = (({1'b0, guard_q} + (GW+1)'(1)) < (GW+1)'(htw_pkg::TIMER_COUNT));
	assign more     = (succ_q < htw_pkg::TC_LINK) && guard_lt;
	assign x_last   = !((nx_rdata < htw_pkg::TC_LINK) && guard_lt);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = out_free &&
		((cmd.step == htw_pkg::ST_RSP) || (cmd.step == htw_pkg::ST_X1));

	always_comb begin
		hd_re = 1'b0; hd_raddr = rslot; hd_we = 1'b0; hd_waddr = rslot;
		hd_wdata = htw_pkg::NIL;
		tl_re = 1'b0; tl_raddr = fslot; tl_we = 1'b0; tl_waddr = rslot;
		tl_wdata = htw_pkg::NIL;
		nx_re = 1'b0; nx_raddr = cur_id; nx_we = 1'b0; nx_waddr = fid_q;
		nx_wdata = htw_pkg::NIL;
		pv_re = 1'b0; pv_raddr = id_q; pv_we = 1'b0; pv_waddr = fid_q; pv_wdata = tl_rdata;
		ex_re = 1'b0; ex_raddr = cur_id; ex_we = 1'b0; ex_waddr = id_q; ex_wdata = arm_exp;
		pd_re = 1'b0; pd_raddr = cur_id; pd_we = 1'b0; pd_waddr = id_q; pd_wdata = per_q;
		ns_re = 1'b0; ns_raddr = id_q; ns_we = 1'b0; ns_waddr = fid_q; ns_wdata = fslot;
		unique case (cmd.step)
			htw_pkg::ST_CLR: begin
				hd_we = 1'b1; hd_waddr = clr_q;
				tl_we = 1'b1; tl_waddr = clr_q;
			end
			htw_pkg::ST_U0: begin
				nx_re = 1'b1; nx_raddr = id_q;
				pv_re = 1'b1;
				ns_re = 1'b1;
			end
			htw_pkg::ST_U1: begin
				// bridge the neighbors, or fix the slot ends
				if (pv_rdata < htw_pkg::TC_LINK) begin
					nx_we = 1'b1; nx_waddr = pv_rdata[IW-1:0]; nx_wdata = nx_rdata;
				end else begin
					hd_we = 1'b1; hd_waddr = ns_rdata; hd_wdata = nx_rdata;
				end
				if (nx_rdata < htw_pkg::TC_LINK) begin
					pv_we = 1'b1; pv_waddr = nx_rdata[IW-1:0]; pv_wdata = pv_rdata;
				end else begin
					tl_we = 1'b1; tl_waddr = ns_rdata; tl_wdata = pv_rdata;
				end
			end
			htw_pkg::ST_ARM: begin
				ex_we = 1'b1;
				pd_we = 1'b1;
			end
			htw_pkg::ST_F0: begin
				tl_re = 1'b1;
				ns_we = 1'b1;
			end
			htw_pkg::ST_F1: begin
				pv_we = 1'b1;
				nx_we = 1'b1;
				tl_we = 1'b1; tl_waddr = slot_q; tl_wdata = LW'(fid_q);
			end
			htw_pkg::ST_F2: begin
				if (tail_q < htw_pkg::TC_LINK) begin
					nx_we = 1'b1; nx_waddr = tail_q[IW-1:0]; nx_wdata = LW'(fid_q);
				end else begin
					hd_we = 1'b1; hd_waddr = slot_q; hd_wdata = LW'(fid_q);
				end
			end
			htw_pkg::ST_C0: begin
				hd_re = 1'b1; hd_raddr = cslot;
				hd_we = 1'b1; hd_waddr = cslot;
				tl_we = 1'b1; tl_waddr = cslot;
			end
			htw_pkg::ST_W0: begin
				nx_re = 1'b1;
				ex_re = 1'b1;
			end
			htw_pkg::ST_E0: begin
				hd_re = 1'b1;
				hd_we = 1'b1;
				tl_we = 1'b1;
			end
			htw_pkg::ST_X0: begin
				nx_re = 1'b1;
				pd_re = 1'b1;
			end
			htw_pkg::ST_X1: begin
				if (out_free && per_nz) begin
					ex_we = 1'b1; ex_waddr = cur_id; ex_wdata = rearm_exp;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			active_q    <= '0;
			clr_q       <= '0;
			guard_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.step == htw_pkg::ST_CLR) clr_q <= clr_q + SW'(1);
			if (cmd.step == htw_pkg::ST_ARM) active_q[id_q] <= 1'b1;
			if (cmd.step == htw_pkg::ST_CANCEL) active_q[id_q] <= 1'b0;
			if (cmd.step == htw_pkg::ST_X1 && out_free && !per_nz) active_q[cur_id] <= 1'b0;
			if ((cmd.step == htw_pkg::ST_C0) || (cmd.step == htw_pkg::ST_E0)) guard_q <= '0;
			if ((cmd.step == htw_pkg::ST_WN) || (cmd.step == htw_pkg::ST_X2)) begin
				guard_q <= guard_q + GW'(1);
			end
			// advance the tick once the current root slot is done
			if ((cmd.step == htw_pkg::ST_RSP && out_free && op_q == htw_pkg::OP_TICK) ||
			    (cmd.step == htw_pkg::ST_X2 && !more)) begin
				tick_q <= tick_q + TW'(1);
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q  <= operation;
			id_q  <= timer_id;
			due_q <= due_time;
			per_q <= period;
		end
		unique case (cmd.step)
			htw_pkg::ST_DEC: begin
				stat_q <= (op_q == htw_pkg::OP_CANCEL) &&
					!(sts.id_ok && active_q[id_q]);
				k_q    <= '0;
			end
			htw_pkg::ST_ARM: begin
				exp_q <= arm_exp;
				fid_q <= id_q;
			end
			htw_pkg::ST_F0: slot_q <= fslot;
			htw_pkg::ST_F1: tail_q <= tl_rdata;
			htw_pkg::ST_C0: izero_q <= (cidx == '0);
			htw_pkg::ST_C1, htw_pkg::ST_E1: cur_q <= hd_rdata;
			htw_pkg::ST_W1: begin
				succ_q <= nx_rdata;
				exp_q  <= ex_rdata;
				fid_q  <= cur_id;
			end
			htw_pkg::ST_WN, htw_pkg::ST_X2: cur_q <= succ_q;
			htw_pkg::ST_LVL: begin
				if (!sts.lvl_stop) k_q <= k_q + htw_pkg::K_W'(1);
			end
			htw_pkg::ST_X1: begin
				if (out_free) begin
					succ_q <= nx_rdata;
					exp_q  <= rearm_exp;
					fid_q  <= cur_id;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			if (cmd.step == htw_pkg::ST_X1) begin
				out_ev_q   <= 1'b1;
				out_id_q   <= cur_id;
				out_st_q   <= 1'b0;
				out_last_q <= x_last;
			end else begin
				out_ev_q   <= 1'b0;
				out_id_q   <= '0;
				out_st_q   <= stat_q;
				out_last_q <= 1'b1;
			end
		end
	end

	htw_ram #(.WIDTH(LW), .DEPTH(htw_pkg::SLOT_COUNT)) u_head (
		.clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
		.re(hd_re), .raddr(hd_raddr), .rdata(hd_rdata)
	);
	htw_ram #(.WIDTH(LW), .DEPTH(htw_pkg::SLOT_COUNT)) u_tail (
		.clk(clk), .we(tl_we), .waddr(tl_waddr), .wdata(tl_wdata),
		.re(tl_re), .raddr(tl_raddr), .rdata(tl_rdata)
	);
	htw_ram #(.WIDTH(LW), .DEPTH(htw_pkg::NODE_DEPTH)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
		.re(nx_re), .raddr(nx_raddr), .rdata(nx_rdata)
	);
	htw_ram #(.WIDTH(LW), .DEPTH(htw_pkg::NODE_DEPTH)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
		.re(pv_re), .raddr(pv_raddr), .rdata(pv_rdata)
	);
	htw_ram #(.WIDTH(TW), .DEPTH(htw_pkg::NODE_DEPTH)) u_expiry (
		.clk(clk), .we(ex_we), .waddr(ex_waddr), .wdata(ex_wdata),
		.re(ex_re), .raddr(ex_raddr), .rdata(ex_rdata)
	);
	htw_ram #(.WIDTH(TW), .DEPTH(htw_pkg::NODE_DEPTH)) u_period (
		.clk(clk), .we(pd_we), .waddr(pd_waddr), .wdata(pd_wdata),
		.re(pd_re), .raddr(pd_raddr), .rdata(pd_rdata)
	);
	htw_ram #(.WIDTH(SW), .DEPTH(htw_pkg::NODE_DEPTH)) u_nslot (
		.clk(clk), .we(ns_we), .waddr(ns_waddr), .wdata(ns_wdata),
		.re(ns_re), .raddr(ns_raddr), .rdata(ns_rdata)
	);

	always_comb begin
		sts.clr_done  = (clr_q == SW'(htw_pkg::SLOT_COUNT - 1));
		sts.id_ok     = (LW'(id_q) < htw_pkg::TC_LINK);
		sts.id_active = active_q[id_q];
		sts.root_zero = (tick_q[htw_pkg::ROOT_BITS-1:0] == '0);
		sts.head_ok   = (hd_rdata < htw_pkg::TC_LINK);
		sts.more      = more;
		sts.lvl_stop  = !izero_q || (k_q == htw_pkg::K_W'(htw_pkg::LEVELS - 1));
		sts.out_free  = out_free;
		sts.per_nz    = per_nz;
		sts.op        = op_q;
	end

	assign out_valid     = out_valid_q;
	assign expired_valid = out_ev_q;
	assign expired_id    = out_id_q;
	assign status        = out_st_q;
	assign last          = out_last_q;

	`HTW_ASSERT_NOW(a_file_active, cmd.step == htw_pkg::ST_F0, active_q[fid_q], "filing an inactive timer")
	`HTW_ASSERT_ALWAYS(a_guard_range, guard_q <= GW'(htw_pkg::TIMER_COUNT), "walk guard overrun")
	`HTW_ASSERT_NEXT(a_tick_step, (cmd.step == htw_pkg::ST_X2) && !more, tick_q == $past(tick_q) + TW'(1), "tick did not advance")
	`HTW_ASSERT_NEXT(a_rsp_last, (cmd.step == htw_pkg::ST_RSP) && out_free, out_valid_q && out_last_q, "response not marked last")

endmodule

`default_nettype wire

### sv/hierarchical_timer_wheel.sv
// Arm decodes, unlinks the timer if already active, writes its expiry and period, then files
// it in its slot; cancel unlinks an active timer; both end by loading the result register.
// Tick: cascades when the root index wraps to zero, then reports each expired timer of the
// root slot, refiling it if it reloads; every node-memory access waits a registered read.
// One transaction is in work at a time; the next is accepted while a result still waits.
// Reset: async, active low; then a pass over all 512 slots empties the slot memories, input stalled.
// ----------------------------------------------------------------------------
// Hierarchical timer wheel
// Five-level cascading wheel over a pool of timers kept in linked slot lists.
// ----------------------------------------------------------------------------
`default_nettype none

module hierarchical_timer_wheel (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [htw_pkg::OP_W-1:0]    operation,
	input  wire logic [htw_pkg::ID_W-1:0]    timer_id,
	input  wire logic [htw_pkg::TICK_W-1:0]  due_time,
	input  wire logic [htw_pkg::TICK_W-1:0]  period,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             expired_valid,
	output logic      [htw_pkg::ID_W-1:0]    expired_id,
	output logic                             status,
	output logic                             last
);

	htw_pkg::cmd_t cmd;
	htw_pkg::sts_t sts;

	htw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	htw_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.timer_id      (timer_id),
		.due_time      (due_time),
		.period        (period),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.expired_valid (expired_valid),
		.expired_id    (expired_id),
		.status        (status),
		.last          (last)
	);

endmodule

`default_nettype wire
